/* src/fcc_pkg.sv */
// ----------------------------------------------------------------------------
// fcc_pkg
// types, constants and state codes for the fan curve controller
// ----------------------------------------------------------------------------
package fcc_pkg;

  localparam int CURVE_POINTS = 16;
  localparam int IDX_W = (CURVE_POINTS > 1) ? $clog2(CURVE_POINTS) : 1;
  localparam int CNT_W = $clog2(CURVE_POINTS + 1);

  localparam int MILLI_PER_DEGREE = 1000;
  // reciprocal of 1000 scaled by 2^26, exact for readings below 2^18
  localparam logic [16:0] RECIP_1000 = 17'd67109;
  localparam int RECIP_SHIFT = 26;
  localparam int Q16_ONE = 65536;
  localparam int Q16_HALF = 32768;
  localparam logic [6:0] EMPTY_CURVE_LEVEL = 7'd15;
  localparam logic [16:0] ALPHA_RESET = 17'd6554;
  localparam logic [7:0] HYST_RESET = 8'd5;

  localparam logic [1:0] CFG_ALPHA_WEIGHT = 2'd0;
  localparam logic [1:0] CFG_HYSTERESIS = 2'd1;
  localparam logic [1:0] CFG_CURVE_LENGTH = 2'd2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [17:0] reading_millideg;
    logic [3:0]  point_index;
    logic [7:0]  point_temp;
    logic [6:0]  point_level;
  } fcc_in_t;

  typedef struct packed {
    logic [7:0] raw_degrees;
    logic [7:0] smoothed_degrees;
    logic [6:0] curve_level;
    logic [6:0] fan_level;
  } fcc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_NEW,
    ST_MUL_OLD,
    ST_AVG,
    ST_SMOOTH,
    ST_SCAN,
    ST_HYST
  } fcc_state_e;

endpackage

/* src/fan_curve_controller_core.sv */
// ----------------------------------------------------------------------------
// fan_curve_controller_core
// one sensor channel: millidegree to degree conversion, moving average,
// step-function curve lookup and falling-edge hysteresis
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  command   in         start / busy                item_i   (fcc_in_t)
//  result    out        result_valid_o, 1 cycle     result_o (fcc_out_t)
//  config    in         cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
//  a curve load completes in the cycle of its transfer and keeps busy low
//  a sample keeps busy high through ST_DIV, dividing by 1000 through the
//  shared 17x24 multiplier, ST_MUL_NEW, ST_MUL_OLD and ST_AVG through it and
//  the adder for the average except on the first sample, ST_SMOOTH to round,
//  ST_SCAN for the curve lookup, ST_HYST for hysteresis; the strobe comes next
//  reset restores configuration defaults, clears average and hysteresis state, not the curve
//  results cannot be stalled; the next command may start in the strobe cycle
// ----------------------------------------------------------------------------
module fan_curve_controller_core
  import fcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  fcc_in_t     item_i,
  output logic        result_valid_o,
  output fcc_out_t    result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  fcc_state_e state_q, state_d;

  logic [16:0] alpha_q;
  logic [7:0]  hyst_q;
  logic [4:0]  len_q;

  logic [7:0]  curve_temps [CURVE_POINTS];
  logic [6:0]  curve_levels [CURVE_POINTS];

  logic [17:0] reading_q, reading_d;
  logic [7:0]  raw_q, raw_d;
  logic [23:0] acc_q, acc_d;
  logic [40:0] prod_q, prod_d;
  logic [23:0] avg_q, avg_d;
  logic        seeded_q, seeded_d;
  logic [7:0]  smooth_q, smooth_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [6:0]  lvl_q, lvl_d;
  logic [6:0]  held_q, held_d;
  logic [7:0]  last_q, last_d;
  logic        res_valid_q, res_valid_d;
  fcc_out_t    res_q, res_d;

  logic        cmd_xfer;
  logic [16:0] alpha_c;
  logic [16:0] mul_x;
  logic [23:0] mul_y;
  logic [40:0] mul_p;
  logic [40:0] prod_rnd;
  logic [24:0] avg_rnd;
  logic [CNT_W-1:0] len_c;
  logic [8:0]  hyst_sum;

  assign cmd_xfer = start && !busy;
  assign busy = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign result_valid_o = res_valid_q;
  assign result_o = res_q;

  assign alpha_c = (alpha_q > 17'(Q16_ONE)) ? 17'(Q16_ONE) : alpha_q;
  assign len_c = (32'(len_q) > CURVE_POINTS) ? CNT_W'(CURVE_POINTS) : CNT_W'(len_q);

  // shared multiplier
  always_comb begin
    case (state_q)
      ST_DIV: begin
        mul_x = RECIP_1000;
        mul_y = 24'(reading_q);
      end
      ST_MUL_OLD: begin
        mul_x = 17'(Q16_ONE) - alpha_c;
        mul_y = avg_q;
      end
      default: begin
        mul_x = alpha_c;
        mul_y = 24'(raw_q);
      end
    endcase
  end
  assign mul_p = 41'(mul_x) * 41'(mul_y);

  assign prod_rnd = prod_q + 41'(Q16_HALF);
  assign avg_rnd = {1'b0, avg_q} + 25'(Q16_HALF);
  assign hyst_sum = {1'b0, smooth_q} + {1'b0, hyst_q};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RESET;
      hyst_q <= HYST_RESET;
      len_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ALPHA_WEIGHT: alpha_q <= cfg_data_i;
        CFG_HYSTERESIS:   hyst_q <= cfg_data_i[7:0];
        CFG_CURVE_LENGTH: len_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // curve table
  always_ff @(posedge clk_i) begin
    if (cmd_xfer && item_i.kind == KIND_LOAD && 32'(item_i.point_index) < CURVE_POINTS) begin
      curve_temps[IDX_W'(item_i.point_index)] <= item_i.point_temp;
      curve_levels[IDX_W'(item_i.point_index)] <= item_i.point_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      avg_q <= '0;
      seeded_q <= 1'b0;
      held_q <= '0;
      last_q <= '0;
      res_valid_q <= 1'b0;
      idx_q <= '0;
      n_q <= '0;
    end else begin
      state_q <= state_d;
      avg_q <= avg_d;
      seeded_q <= seeded_d;
      held_q <= held_d;
      last_q <= last_d;
      res_valid_q <= res_valid_d;
      idx_q <= idx_d;
      n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reading_q <= reading_d;
    raw_q <= raw_d;
    acc_q <= acc_d;
    prod_q <= prod_d;
    smooth_q <= smooth_d;
    lvl_q <= lvl_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d = state_q;
    reading_d = reading_q;
    raw_d = raw_q;
    acc_d = acc_q;
    prod_d = prod_q;
    avg_d = avg_q;
    seeded_d = seeded_q;
    smooth_d = smooth_q;
    n_d = n_q;
    idx_d = idx_q;
    lvl_d = lvl_q;
    held_d = held_q;
    last_d = last_q;
    res_valid_d = 1'b0;
    res_d = res_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_xfer && item_i.kind == KIND_SAMPLE) begin
          reading_d = item_i.reading_millideg;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        raw_d = mul_p[RECIP_SHIFT+8] ? 8'd255 : mul_p[RECIP_SHIFT+7:RECIP_SHIFT];
        if (seeded_q) begin
          state_d = ST_MUL_NEW;
        end else begin
          avg_d = {raw_d, 16'd0};
          seeded_d = 1'b1;
          state_d = ST_SMOOTH;
        end
      end
      ST_MUL_NEW: begin
        acc_d = mul_p[23:0];
        state_d = ST_MUL_OLD;
      end
      ST_MUL_OLD: begin
        prod_d = mul_p;
        state_d = ST_AVG;
      end
      ST_AVG: begin
        avg_d = acc_q + prod_rnd[39:16];
        state_d = ST_SMOOTH;
      end
      ST_SMOOTH: begin
        smooth_d = avg_rnd[24] ? 8'd255 : avg_rnd[23:16];
        n_d = len_c;
        idx_d = '0;
        if (len_c == '0) begin
          lvl_d = EMPTY_CURVE_LEVEL;
          state_d = ST_HYST;
        end else begin
          lvl_d = curve_levels[0];
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q == n_q || smooth_q < curve_temps[idx_q[IDX_W-1:0]]) begin
          state_d = ST_HYST;
        end else begin
          lvl_d = curve_levels[idx_q[IDX_W-1:0]];
          idx_d = idx_q + CNT_W'(1);
        end
      end
      ST_HYST: begin
        if (lvl_q > held_q || (lvl_q < held_q && hyst_sum <= {1'b0, last_q})) begin
          held_d = lvl_q;
          last_d = smooth_q;
        end
        res_d.raw_degrees = raw_q;
        res_d.smoothed_degrees = smooth_q;
        res_d.curve_level = lvl_q;
        res_d.fan_level = held_d;
        res_valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // a result strobe lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // a sample transfer makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.kind == KIND_SAMPLE) |=> busy)
    else $error("sample transfer did not start processing");

  // the scan index never passes the curve length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q <= n_q))
    else $error("curve scan ran past the curve length");

  // once seeded the average stays seeded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seeded_q |=> seeded_q)
    else $error("average seed flag dropped");

endmodule
